[hw/rtl/ians_pkg.sv]
// ----------------------------------------------------------------------------
// ians_pkg
// Shared constants, widths, codes and types of the inverse affine sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package ians_pkg;

	// frame geometry and number formats
	localparam int FRAME_WIDTH  = 32;
	localparam int FRAME_HEIGHT = 32;
	localparam int FRAC_BITS    = 12;
	localparam int PIXEL_BITS   = 32;

	// port widths
	localparam int COEF_W = 16;
	localparam int CRD_W  = 5;
	localparam int DATA_W = 32;
	localparam int APB_DW = 32;
	localparam int APB_AW = 4;
	localparam int REG_IDX_W = 2;

	// inverse matrix arithmetic
	localparam int DET_W  = 2 * COEF_W + 1;
	localparam int S_W    = DET_W - FRAC_BITS;
	localparam int NUM_W  = COEF_W + FRAC_BITS + 1;
	localparam int QMAG_W = NUM_W - 1;
	localparam int INV_W  = NUM_W;
	localparam int QCNT_W = $clog2(QMAG_W + 1);

	// coordinate mapping
	localparam int OFS_W  = CRD_W + 2;
	localparam int PROD_W = OFS_W + INV_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int IDX_W  = SUM_W - FRAC_BITS;
	localparam int ADDR_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
	localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;

	localparam int CX    = FRAME_WIDTH / 2;
	localparam int CY    = FRAME_HEIGHT / 2;
	localparam int HALF  = (5 * (2 ** FRAC_BITS)) / 10;
	localparam int OFF_X = CX * (2 ** FRAC_BITS) + HALF;
	localparam int OFF_Y = CY * (2 ** FRAC_BITS) + HALF;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_A = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_B = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_C = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_D = 2'd3;

	// reset values of the forward matrix
	localparam logic signed [COEF_W-1:0] COEF_A_RST = 16'sd2048;
	localparam logic signed [COEF_W-1:0] COEF_B_RST = 16'sd0;
	localparam logic signed [COEF_W-1:0] COEF_C_RST = 16'sd0;
	localparam logic signed [COEF_W-1:0] COEF_D_RST = 16'sd2048;

	typedef struct packed {
		logic              opcode;
		logic [CRD_W-1:0]  col;
		logic [CRD_W-1:0]  row;
		logic [DATA_W-1:0] pixel;
	} item_t;

	typedef struct packed {
		logic signed [INV_W-1:0] ia;
		logic signed [INV_W-1:0] ib;
		logic signed [INV_W-1:0] ic;
		logic signed [INV_W-1:0] id;
		logic                    sing;
		logic                    m_neg;
		logic                    n_neg;
		logic                    busy;
	} xform_t;

endpackage

`default_nettype wire

[hw/rtl/ians_stream_if.sv]
// ----------------------------------------------------------------------------
// ians stream interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ians_req_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [ians_pkg::CRD_W-1:0]   col;
	logic [ians_pkg::CRD_W-1:0]   row;
	logic [ians_pkg::DATA_W-1:0]  pixel_in;
	modport source(output valid, opcode, col, row, pixel_in, input ready);
	modport sink(input valid, opcode, col, row, pixel_in, output ready);
endinterface

interface ians_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ians_pkg::DATA_W-1:0]  pixel_out;
	logic                         in_frame;
	logic                         singular;
	modport source(output valid, pixel_out, in_frame, singular, input ready);
	modport sink(input valid, pixel_out, in_frame, singular, output ready);
endinterface

`default_nettype wire

[hw/rtl/ians_front.sv]
// ----------------------------------------------------------------------------
// ians_front
// Register port, inverse matrix sequencer and two-word request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ians_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [ians_pkg::APB_AW-1:0]       paddr,
	input  wire [ians_pkg::APB_DW-1:0]       pwdata,
	output logic [ians_pkg::APB_DW-1:0]      prdata,
	output logic                             pready,
	ians_req_if.sink                         req,
	output ians_pkg::item_t                  head,
	output logic                             head_valid,
	input  wire                              pop,
	output ians_pkg::xform_t                 xf
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DET  = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;

	logic signed [ians_pkg::COEF_W-1:0]   coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic [2:0]                           state_q;
	logic signed [2*ians_pkg::COEF_W-1:0] prod_ad_q, prod_bc_q;
	logic [ians_pkg::S_W-1:0]             s_mag_q;
	logic                                 s_neg_q;
	logic                                 sing_q;
	logic [1:0]                           k_q;
	logic [ians_pkg::S_W-1:0]             rem_q;
	logic [ians_pkg::QMAG_W-1:0]          quo_q;
	logic                                 neg_q;
	logic [ians_pkg::QCNT_W-1:0]          cnt_q;
	logic signed [ians_pkg::INV_W-1:0]    inv_q [4];

	logic                                 wr;
	logic [ians_pkg::REG_IDX_W-1:0]       widx;
	logic signed [ians_pkg::DET_W-1:0]    det_c;
	logic signed [ians_pkg::S_W-1:0]      s_c;
	logic signed [ians_pkg::COEF_W-1:0]   csel;
	logic                                 cneg;
	logic signed [ians_pkg::NUM_W-1:0]    num_c;
	logic [ians_pkg::QMAG_W-1:0]          nmag_c;
	logic [ians_pkg::S_W:0]               trial_c;
	logic [ians_pkg::S_W-1:0]             rem_n;
	logic [ians_pkg::QMAG_W-1:0]          quo_n;

	ians_pkg::item_t                      qmem_q [2];
	logic                                 wp_q, rp_q;
	logic [1:0]                           qcnt_q;
	logic                                 push;

	// register port
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign widx   = paddr[ians_pkg::APB_AW-1 -: ians_pkg::REG_IDX_W];

	always_comb begin
		case (widx)
			ians_pkg::REG_A: prdata = ians_pkg::APB_DW'($unsigned(coef_a_q));
			ians_pkg::REG_B: prdata = ians_pkg::APB_DW'($unsigned(coef_b_q));
			ians_pkg::REG_C: prdata = ians_pkg::APB_DW'($unsigned(coef_c_q));
			ians_pkg::REG_D: prdata = ians_pkg::APB_DW'($unsigned(coef_d_q));
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= ians_pkg::COEF_A_RST;
			coef_b_q <= ians_pkg::COEF_B_RST;
			coef_c_q <= ians_pkg::COEF_C_RST;
			coef_d_q <= ians_pkg::COEF_D_RST;
		end else if (wr) begin
			case (widx)
				ians_pkg::REG_A: coef_a_q <= pwdata[ians_pkg::COEF_W-1:0];
				ians_pkg::REG_B: coef_b_q <= pwdata[ians_pkg::COEF_W-1:0];
				ians_pkg::REG_C: coef_c_q <= pwdata[ians_pkg::COEF_W-1:0];
				ians_pkg::REG_D: coef_d_q <= pwdata[ians_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// determinant and its scaled value
	assign det_c = ians_pkg::DET_W'(prod_ad_q) - ians_pkg::DET_W'(prod_bc_q);
	assign s_c   = ians_pkg::S_W'(det_c >>> ians_pkg::FRAC_BITS);

	// numerator of the inverse element under work
	always_comb begin
		case (k_q)
			2'd0:    begin csel = coef_d_q; cneg = 1'b0; end
			2'd1:    begin csel = coef_b_q; cneg = 1'b1; end
			2'd2:    begin csel = coef_c_q; cneg = 1'b1; end
			default: begin csel = coef_a_q; cneg = 1'b0; end
		endcase
	end

	always_comb begin
		num_c = ians_pkg::NUM_W'(csel) <<< ians_pkg::FRAC_BITS;
		if (cneg) begin
			num_c = -num_c;
		end
		nmag_c = num_c[ians_pkg::NUM_W-1] ? ians_pkg::QMAG_W'(-num_c)
		                                   : ians_pkg::QMAG_W'(num_c);
	end

	// one restoring division step
	always_comb begin
		trial_c = {rem_q, quo_q[ians_pkg::QMAG_W-1]} - {1'b0, s_mag_q};
		if (!trial_c[ians_pkg::S_W]) begin
			rem_n = trial_c[ians_pkg::S_W-1:0];
		end else begin
			rem_n = {rem_q[ians_pkg::S_W-2:0], quo_q[ians_pkg::QMAG_W-1]};
		end
		quo_n = {quo_q[ians_pkg::QMAG_W-2:0], ~trial_c[ians_pkg::S_W]};
	end

	// inverse sequencer: multiply, determinant, then four divisions unless the matrix is singular
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MUL;
			sing_q  <= 1'b0;
			k_q     <= 2'd0;
			cnt_q   <= '0;
		end else if (wr) begin
			state_q <= ST_MUL;
		end else begin
			case (state_q)
				ST_MUL: begin
					state_q <= ST_DET;
				end
				ST_DET: begin
					sing_q <= (s_c == '0);
					k_q    <= 2'd0;
					state_q <= (s_c == '0) ? ST_IDLE : ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q   <= ians_pkg::QCNT_W'(ians_pkg::QMAG_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == ians_pkg::QCNT_W'(1)) begin
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? ST_IDLE : ST_LOAD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				prod_ad_q <= coef_a_q * coef_d_q;
				prod_bc_q <= coef_b_q * coef_c_q;
			end
			ST_DET: begin
				s_neg_q <= s_c[ians_pkg::S_W-1];
				s_mag_q <= s_c[ians_pkg::S_W-1] ? ians_pkg::S_W'(-s_c) : ians_pkg::S_W'(s_c);
			end
			ST_LOAD: begin
				rem_q <= '0;
				quo_q <= nmag_c;
				neg_q <= num_c[ians_pkg::NUM_W-1] ^ s_neg_q;
			end
			ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				if (cnt_q == ians_pkg::QCNT_W'(1)) begin
					inv_q[k_q] <= neg_q ? -ians_pkg::INV_W'(quo_n) : ians_pkg::INV_W'(quo_n);
				end
			end
			default: ;
		endcase
	end

	assign xf.ia    = inv_q[0];
	assign xf.ib    = inv_q[1];
	assign xf.ic    = inv_q[2];
	assign xf.id    = inv_q[3];
	assign xf.sing  = sing_q;
	assign xf.m_neg = coef_a_q[ians_pkg::COEF_W-1];
	assign xf.n_neg = coef_d_q[ians_pkg::COEF_W-1];
	assign xf.busy  = (state_q != ST_IDLE);

	// request queue
	assign req.ready  = !xf.busy && (qcnt_q != 2'd2);
	assign push       = req.valid && req.ready;
	assign head_valid = (qcnt_q != 2'd0);
	assign head       = qmem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			qmem_q[wp_q] <= '{opcode: req.opcode, col: req.col, row: req.row,
			                  pixel: req.pixel_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			qcnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   qcnt_q <= qcnt_q + 1'b1;
				2'b01:   qcnt_q <= qcnt_q - 1'b1;
				default: qcnt_q <= qcnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ians_back.sv]
// ----------------------------------------------------------------------------
// ians_back
// Coordinate mapping pipeline, source frame memory and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ians_back (
	input  wire              clk,
	input  wire              arst_n,
	input  ians_pkg::item_t  head,
	input  wire              head_valid,
	output logic             pop,
	input  ians_pkg::xform_t xf,
	ians_rsp_if.source       rsp
);

	logic                                 en;
	logic signed [ians_pkg::OFS_W-1:0]    ofs_x, ofs_y;
	logic signed [ians_pkg::SUM_W-1:0]    sum_x, sum_y;
	logic signed [ians_pkg::IDX_W-1:0]    ix, iy;
	logic                                 hit_rd, hit_wr;

	logic                                 v_s1, op_s1;
	logic [ians_pkg::CRD_W-1:0]           col_s1, row_s1;
	logic [ians_pkg::DATA_W-1:0]          pix_s1;
	logic signed [ians_pkg::PROD_W-1:0]   pa_s1, pb_s1, pc_s1, pd_s1;

	logic                                 v_s2, op_s2, hit_s2;
	logic [ians_pkg::ADDR_W-1:0]          addr_s2;
	logic [ians_pkg::DATA_W-1:0]          pix_s2;

	logic                                 v_s3, op_s3, hit_s3, sing_s3;
	logic [ians_pkg::PIXEL_BITS-1:0]      rd_s3;

	logic [ians_pkg::PIXEL_BITS-1:0]      mem [ians_pkg::DEPTH];

	logic                                 rsp_valid_q, in_frame_q, singular_q;
	logic [ians_pkg::DATA_W-1:0]          pixel_out_q;

	// advance the whole pipe whenever the response register can take a word
	assign en  = !rsp_valid_q || rsp.ready;
	assign pop = en && head_valid;

	// centered coordinates with the sign offsets folded in
	assign ofs_x = {{(ians_pkg::OFS_W-ians_pkg::CRD_W){1'b0}}, head.col}
	             - ians_pkg::OFS_W'(ians_pkg::CX) + ians_pkg::OFS_W'(xf.m_neg);
	assign ofs_y = {{(ians_pkg::OFS_W-ians_pkg::CRD_W){1'b0}}, head.row}
	             - ians_pkg::OFS_W'(ians_pkg::CY) + ians_pkg::OFS_W'(xf.n_neg);

	// stage 1: products with the inverse matrix
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= head.opcode;
			col_s1 <= head.col;
			row_s1 <= head.row;
			pix_s1 <= head.pixel;
			pa_s1  <= ofs_x * xf.ia;
			pb_s1  <= ofs_y * xf.ib;
			pc_s1  <= ofs_x * xf.ic;
			pd_s1  <= ofs_y * xf.id;
		end
	end

	// stage 2: sums, rounding, frame check and address
	assign sum_x = ians_pkg::SUM_W'(pa_s1) + ians_pkg::SUM_W'(pb_s1)
	             + ians_pkg::SUM_W'(ians_pkg::OFF_X);
	assign sum_y = ians_pkg::SUM_W'(pc_s1) + ians_pkg::SUM_W'(pd_s1)
	             + ians_pkg::SUM_W'(ians_pkg::OFF_Y);
	assign ix    = ians_pkg::IDX_W'(sum_x >>> ians_pkg::FRAC_BITS);
	assign iy    = ians_pkg::IDX_W'(sum_y >>> ians_pkg::FRAC_BITS);

	assign hit_rd = !xf.sing
	             && !ix[ians_pkg::IDX_W-1] && (ix < ians_pkg::IDX_W'(ians_pkg::FRAME_WIDTH))
	             && !iy[ians_pkg::IDX_W-1] && (iy < ians_pkg::IDX_W'(ians_pkg::FRAME_HEIGHT));
	assign hit_wr = (32'(col_s1) < ians_pkg::FRAME_WIDTH)
	             && (32'(row_s1) < ians_pkg::FRAME_HEIGHT);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			pix_s2 <= pix_s1;
			if (op_s1 == ians_pkg::OP_READ) begin
				hit_s2  <= hit_rd;
				addr_s2 <= ians_pkg::ADDR_W'(iy) * ians_pkg::ADDR_W'(ians_pkg::FRAME_WIDTH)
				         + ians_pkg::ADDR_W'(ix);
			end else begin
				hit_s2  <= hit_wr;
				addr_s2 <= ians_pkg::ADDR_W'(row_s1) * ians_pkg::ADDR_W'(ians_pkg::FRAME_WIDTH)
				         + ians_pkg::ADDR_W'(col_s1);
			end
		end
	end

	// stage 3: frame memory, a read for every word and a write for a write word that hits the frame
	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			if (op_s2 == ians_pkg::OP_WRITE && hit_s2) begin
				mem[addr_s2] <= pix_s2[ians_pkg::PIXEL_BITS-1:0];
			end
			rd_s3 <= mem[addr_s2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3   <= op_s2;
			hit_s3  <= hit_s2;
			sing_s3 <= xf.sing;
		end
	end

	// response payload, zero outside the frame
	always_ff @(posedge clk) begin
		if (en) begin
			pixel_out_q <= hit_s3 ? ians_pkg::DATA_W'(rd_s3) : '0;
			in_frame_q  <= hit_s3;
			singular_q  <= sing_s3;
		end
	end

	// stage valids and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			rsp_valid_q <= v_s3 && (op_s3 == ians_pkg::OP_READ);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pixel_out = pixel_out_q;
	assign rsp.in_frame  = in_frame_q;
	assign rsp.singular  = singular_q;

endmodule

`default_nettype wire

[hw/rtl/inverse_affine_nearest_sampler_top.sv]
// A read request's response word passes the queue, stages s1, s2 and s3 and the response register.
// Throughput: one word per cycle, reads and writes alike, when no recompute runs and the response side keeps up.
// A register write recomputes the inverse matrix in a shared bit-serial divider:
// req.ready stays low through the multiply, determinant and four divisions (only the first two when singular).
// Reset loads the half-scale matrix (a = d = 0.5) and runs the same recompute first.
// The frame memory is not cleared; a pixel reads back only once written.
`default_nettype none

module inverse_affine_nearest_sampler_top (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [ians_pkg::APB_AW-1:0]  paddr,
	input  wire [ians_pkg::APB_DW-1:0]  pwdata,
	output logic [ians_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	ians_req_if.sink                    req,
	ians_rsp_if.source                  rsp
);

	ians_pkg::item_t  head;
	logic             head_valid;
	logic             pop;
	ians_pkg::xform_t xf;

	// accept, queue and matrix setup
	ians_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req       (req),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.xf        (xf)
	);

	// mapping, memory and response
	ians_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.xf        (xf),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[hw/rtl/ians_checker.sv]
// ----------------------------------------------------------------------------
// ians_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ians_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        req_ready,
	input wire                        rsp_valid,
	input wire                        rsp_ready,
	input wire [ians_pkg::DATA_W-1:0] pixel_out,
	input wire                        in_frame,
	input wire                        singular,
	input wire                        cfg_wr
);

	// hold a stalled response word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_out)
		&& $stable(in_frame) && $stable(singular))
		else $error("stalled response word changed");

	// singular matrix never maps into the frame
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && singular |-> !in_frame && (pixel_out == '0))
		else $error("singular response carries a pixel");

	// outside the frame reads as zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !in_frame |-> (pixel_out == '0))
		else $error("out of frame response not zero");

	// drop ready while the inverse is recomputed
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !req_ready)
		else $error("request taken during matrix recompute");

endmodule

bind inverse_affine_nearest_sampler_top ians_checker u_ians_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.pixel_out(rsp.pixel_out),
	.in_frame (rsp.in_frame),
	.singular (rsp.singular),
	.cfg_wr   (psel & penable & pwrite)
);

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the inverse affine nearest-neighbour sampler.
// Loads the whole source frame, then runs request and write words under a
// series of matrix settings. Every response word is compared against an
// in-bench prediction of the inverse mapping and of the frame contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [ians_pkg::DATA_W-1:0] pixel;
		logic                        in_frame;
		logic                        singular;
	} sample_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ians_pkg::APB_AW-1:0]   paddr;
	logic [ians_pkg::APB_DW-1:0]   pwdata;
	logic [ians_pkg::APB_DW-1:0]   prdata;
	logic                          pready;

	ians_req_if req_if();
	ians_rsp_if rsp_if();

	inverse_affine_nearest_sampler_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	// shadow of the block's matrix and frame
	logic signed [ians_pkg::COEF_W-1:0] coef_shadow [4];
	logic [ians_pkg::DATA_W-1:0]        frame_shadow [ians_pkg::DEPTH];

	ians_pkg::item_t pending_words [$];
	sample_t         expected_samples [$];
	int      fail_count = 0;
	int      reads_seen = 0;
	bit      hold_send = 1'b0;
	bit      long_hold_done = 1'b0;
	int      hold_left = 0;

	// generate clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// give up after a generous time
	initial begin
		#20_000_000;
		$display("inverse_affine_nearest_sampler_top verification failed");
		$finish;
	end

	function automatic bit steady_window();
		return reads_seen >= 350 && reads_seen < 450;
	endfunction

	// map an output pixel back into the source frame
	function automatic sample_t predict_sample(logic [ians_pkg::CRD_W-1:0] col,
			logic [ians_pkg::CRD_W-1:0] row);
		longint a, b, c, d, det, s, ia, ib, ic, id, m, n, ax, ay, rx, ry, ix, iy;
		sample_t r;
		a = coef_shadow[ians_pkg::REG_A];
		b = coef_shadow[ians_pkg::REG_B];
		c = coef_shadow[ians_pkg::REG_C];
		d = coef_shadow[ians_pkg::REG_D];
		r = '0;
		det = a * d - b * c;
		s = det >>> ians_pkg::FRAC_BITS;
		if (s == 0) begin
			r.singular = 1'b1;
			return r;
		end
		ia = (d * (64'sd1 << ians_pkg::FRAC_BITS)) / s;
		ib = (-b * (64'sd1 << ians_pkg::FRAC_BITS)) / s;
		ic = (-c * (64'sd1 << ians_pkg::FRAC_BITS)) / s;
		id = (a * (64'sd1 << ians_pkg::FRAC_BITS)) / s;
		m = (a < 0) ? -1 : 0;
		n = (d < 0) ? -1 : 0;
		ax = longint'(int'(col)) - ians_pkg::CX;
		ay = longint'(int'(row)) - ians_pkg::CY;
		rx = ax * ia + ay * ib - m * ia - n * ib
		   + longint'(ians_pkg::CX) * (64'sd1 << ians_pkg::FRAC_BITS);
		ry = ax * ic + ay * id - m * ic - n * id
		   + longint'(ians_pkg::CY) * (64'sd1 << ians_pkg::FRAC_BITS);
		ix = (rx + ians_pkg::HALF) >>> ians_pkg::FRAC_BITS;
		iy = (ry + ians_pkg::HALF) >>> ians_pkg::FRAC_BITS;
		if (ix < 0 || ix >= ians_pkg::FRAME_WIDTH || iy < 0 || iy >= ians_pkg::FRAME_HEIGHT)
			return r;
		r.pixel = frame_shadow[iy * ians_pkg::FRAME_WIDTH + ix];
		r.in_frame = 1'b1;
		return r;
	endfunction

	// drive request words from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_if.ready) begin
			if (pending_words.size() > 0 && !hold_send
					&& (steady_window() || $urandom_range(99) >= 13)) begin
				ians_pkg::item_t w;
				w = pending_words.pop_front();
				req_if.valid    <= 1'b1;
				req_if.opcode   <= w.opcode;
				req_if.col      <= w.col;
				req_if.row      <= w.row;
				req_if.pixel_in <= w.pixel;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// stall the response side at random, and once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (!long_hold_done && reads_seen >= 150) begin
			long_hold_done <= 1'b1;
			hold_left <= 400;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= steady_window() || $urandom_range(99) >= 13;
		end
	end

	// check response words, then record accepted request words
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected word pixel=%h in_frame=%b singular=%b", $time,
						rsp_if.pixel_out, rsp_if.in_frame, rsp_if.singular);
					fail_count++;
				end else begin
					sample_t e;
					e = expected_samples.pop_front();
					if (rsp_if.pixel_out !== e.pixel) begin
						$display("%0t: pixel_out expected %h got %h", $time, e.pixel,
							rsp_if.pixel_out);
						fail_count++;
					end
					if (rsp_if.in_frame !== e.in_frame) begin
						$display("%0t: in_frame expected %b got %b", $time, e.in_frame,
							rsp_if.in_frame);
						fail_count++;
					end
					if (rsp_if.singular !== e.singular) begin
						$display("%0t: singular expected %b got %b", $time, e.singular,
							rsp_if.singular);
						fail_count++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				if (req_if.opcode == ians_pkg::OP_WRITE) begin
					frame_shadow[req_if.row * ians_pkg::FRAME_WIDTH + req_if.col]
						= req_if.pixel_in;
				end else begin
					expected_samples.push_back(predict_sample(req_if.col, req_if.row));
					reads_seen++;
				end
			end
		end
	end

	task automatic push_word(logic op, int col, int row, logic [ians_pkg::DATA_W-1:0] pixel);
		ians_pkg::item_t w;
		w.opcode = op;
		w.col = ians_pkg::CRD_W'(col);
		w.row = ians_pkg::CRD_W'(row);
		w.pixel = pixel;
		pending_words.push_back(w);
	endtask

	// let the sender run until every word is sent and every expected word is back, then pause it
	task automatic drain();
		hold_send = 1'b0;
		@(negedge clk);
		while (pending_words.size() > 0 || req_if.valid || expected_samples.size() > 0)
			@(negedge clk);
		hold_send = 1'b1;
		repeat (10) @(posedge clk);
	endtask

	// write one matrix register, then wait out the recompute
	task automatic write_coef(logic [ians_pkg::REG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= ians_pkg::APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		coef_shadow[idx] = ians_pkg::COEF_W'(value);
		repeat (2) @(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	task automatic set_matrix(int a, int b, int c, int d);
		write_coef(ians_pkg::REG_A, a);
		write_coef(ians_pkg::REG_B, b);
		write_coef(ians_pkg::REG_C, c);
		write_coef(ians_pkg::REG_D, d);
	endtask

	// mostly reads with a share of frame rewrites
	task automatic random_words(int count);
		repeat (count) begin
			if ($urandom_range(99) < 30)
				push_word(ians_pkg::OP_WRITE, $urandom_range(31), $urandom_range(31),
					$urandom);
			else
				push_word(ians_pkg::OP_READ, $urandom_range(31), $urandom_range(31),
					$urandom);
		end
	endtask

	initial begin
		int settings [10][4] = '{
			'{2048, 0, 0, 2048},
			'{4096, 0, 0, 4096},
			'{-4096, 0, 0, -4096},
			'{0, 0, 0, 0},
			'{1, 0, 0, 1},
			'{32767, -32768, -32768, 32767},
			'{-32768, 32767, 32767, -32768},
			'{3547, -2048, 2048, 3547},
			'{-32768, 0, 0, 32767},
			'{8192, 1024, -512, 6000}
		};
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		req_if.valid    = 1'b0;
		req_if.opcode   = ians_pkg::OP_WRITE;
		req_if.col      = '0;
		req_if.row      = '0;
		req_if.pixel_in = '0;
		rsp_if.ready    = 1'b0;
		coef_shadow[ians_pkg::REG_A] = ians_pkg::COEF_A_RST;
		coef_shadow[ians_pkg::REG_B] = ians_pkg::COEF_B_RST;
		coef_shadow[ians_pkg::REG_C] = ians_pkg::COEF_C_RST;
		coef_shadow[ians_pkg::REG_D] = ians_pkg::COEF_D_RST;
		hold_send = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// load the whole frame so no read hits an unwritten pixel
		for (int r = 0; r < ians_pkg::FRAME_HEIGHT; r++)
			for (int c = 0; c < ians_pkg::FRAME_WIDTH; c++)
				push_word(ians_pkg::OP_WRITE, c, r, $urandom);
		// directed words: pixel extremes, corners and center
		push_word(ians_pkg::OP_WRITE, 0, 0, 32'hFFFF_FFFF);
		push_word(ians_pkg::OP_WRITE, 31, 31, 32'h0000_0000);
		push_word(ians_pkg::OP_WRITE, 31, 0, 32'hAAAA_5555);
		push_word(ians_pkg::OP_WRITE, 0, 31, 32'h5555_AAAA);
		push_word(ians_pkg::OP_READ, 0, 0, 32'hFFFF_FFFF);
		push_word(ians_pkg::OP_READ, 31, 31, '0);
		push_word(ians_pkg::OP_READ, 31, 0, '0);
		push_word(ians_pkg::OP_READ, 0, 31, '0);
		push_word(ians_pkg::OP_READ, 16, 16, '0);
		drain();

		// walk through matrix settings: identity, scale, flip, singular, extremes
		for (int p = 0; p < 10; p++) begin
			set_matrix(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
			push_word(ians_pkg::OP_READ, 0, 0, '0);
			push_word(ians_pkg::OP_READ, 31, 31, '0);
			push_word(ians_pkg::OP_READ, 16, 16, '0);
			random_words(70);
			drain();
		end

		// two random matrices to finish
		repeat (2) begin
			set_matrix($urandom_range(65535), $urandom_range(65535),
				$urandom_range(65535), $urandom_range(65535));
			random_words(60);
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("inverse_affine_nearest_sampler_top verification clean");
		end else begin
			$display("inverse_affine_nearest_sampler_top verification failed");
		end
		$finish;
	end

endmodule
